// ===== hw/rtl/lbh_pkg.sv =====
// ----------------------------------------------------------------------------
// lbh_pkg: shared types and constants of the LSH bucket hash block
// Command and result beat formats, opcode and register codes, the sequencer
// state type and the golden-ratio hash combine step.
// ----------------------------------------------------------------------------
package lbh_pkg;

	// Default sizes of the hash family and of the table set.
	localparam int FAMILY_SIZE_DEF     = 128;
	localparam int NUM_TABLES_DEF      = 16;
	localparam int FUNCS_PER_TABLE_DEF = 8;

	// Number of radius ranks that the block resolves; higher ranks clamp.
	localparam int NUM_RADII = 4;

	// Depths of the command queue and the result queue.
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// Bits kept of a member function index.
	localparam int MIDX_W = 10;

	localparam logic [31:0] GOLDEN    = 32'h9e37_79b9;
	localparam logic [31:0] INV_RESET = 32'h0001_0000;

	// Input opcodes.
	localparam logic [1:0] FUNC_OFFSET = 2'd0;
	localparam logic [1:0] FUNC_MEMBER = 2'd1;
	localparam logic [1:0] FUNC_PROJ   = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_INV_RADIUS_0 = 2'd0;
	localparam logic [1:0] REG_INV_RADIUS_1 = 2'd1;
	localparam logic [1:0] REG_INV_RADIUS_2 = 2'd2;
	localparam logic [1:0] REG_INV_RADIUS_3 = 2'd3;

	typedef enum logic [1:0] {
		CMD_OFFSET,
		CMD_MEMBER,
		CMD_PROJ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [9:0]  slot;
		logic        in_range;
		logic [31:0] value;
		logic [31:0] inv;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  table_number;
		logic [31:0] hash_word;
		logic        last_table;
	} res_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_TSTART,
		ST_HASH,
		ST_WAIT
	} st_t;

	// One fold of the golden-ratio combine, 32-bit wrap.
	function automatic logic [31:0] hash_combine(input logic [31:0] h, input logic [31:0] q);
		return h ^ (q + GOLDEN + {h[25:0], 6'b0} + {2'b0, h[31:2]});
	endfunction

endpackage

// ===== hw/rtl/lbh_ram.sv =====
// ----------------------------------------------------------------------------
// lbh_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/lbh_fifo.sv =====
// ----------------------------------------------------------------------------
// lbh_fifo: small register queue
// Push and pop are gated by full and empty; the head entry is shown directly.
// ----------------------------------------------------------------------------
module lbh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             push_en, pop_en;

	assign full    = (count_q == CNT_MAX);
	assign empty   = (count_q == '0);
	assign push_en = push && !full;
	assign pop_en  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push_en) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_en) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop_en) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push_en && !pop_en) begin
				count_q <= count_q + 1'b1;
			end else if (pop_en && !push_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_en && !pop_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_en && !push_en) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not follow a pop");

endmodule

// ===== hw/rtl/lbh_front.sv =====
// ----------------------------------------------------------------------------
// lbh_front: input decode and radius registers
// Holds the reciprocal radius registers, decodes each input beat into a
// command with its range check and resolved reciprocal radius.
// ----------------------------------------------------------------------------
module lbh_front #(
	parameter int FAMILY_SIZE  = lbh_pkg::FAMILY_SIZE_DEF,
	parameter int MEMBER_DEPTH = lbh_pkg::NUM_TABLES_DEF * lbh_pkg::FUNCS_PER_TABLE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [1:0]         func,
	input  logic [9:0]         slot,
	input  logic signed [31:0] value,
	input  logic [1:0]         radius_rank,
	input  logic               last_element,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output lbh_pkg::cmd_t      cmd,
	output logic               cmd_push
);

	import lbh_pkg::*;

	localparam logic [10:0] FAM_LIM = 11'(FAMILY_SIZE);
	localparam logic [12:0] MEM_LIM = 13'(MEMBER_DEPTH);

	logic [31:0] inv_q [NUM_RADII];
	logic [1:0]  rank_c;
	logic        known;
	logic        fam_ok, mem_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RADII; i++) begin
				inv_q[i] <= INV_RESET;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INV_RADIUS_0: inv_q[0] <= cfg_data;
				REG_INV_RADIUS_1: inv_q[1] <= cfg_data;
				REG_INV_RADIUS_2: inv_q[2] <= cfg_data;
				REG_INV_RADIUS_3: inv_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ranks above the last implemented one use the last one.
	assign rank_c = ({1'b0, radius_rank} >= 3'(NUM_RADII)) ? 2'(NUM_RADII - 1) : radius_rank;

	assign fam_ok = ({1'b0, slot} < FAM_LIM);
	assign mem_ok = ({3'b000, slot} < MEM_LIM);

	always_comb begin
		cmd.slot     = slot;
		cmd.value    = value;
		cmd.inv      = inv_q[rank_c];
		cmd.last     = last_element;
		cmd.kind     = CMD_PROJ;
		cmd.in_range = fam_ok;
		known        = 1'b1;
		unique case (func)
			FUNC_OFFSET: begin
				cmd.kind = CMD_OFFSET;
			end
			FUNC_MEMBER: begin
				cmd.kind     = CMD_MEMBER;
				cmd.in_range = mem_ok;
			end
			FUNC_PROJ: begin
				cmd.kind = CMD_PROJ;
			end
			FUNC_NONE: begin
				known = 1'b0;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// The unused opcode is accepted and dropped here.
	assign cmd_push = push && !full && known;

endmodule

// ===== hw/rtl/lbh_back.sv =====
// ----------------------------------------------------------------------------
// lbh_back: command execution and hash sequencer
// Writes the offset and member stores, quantizes projections through a
// three-stage multiply and round pipeline, and on the last projection walks
// every table's members to fold one hash word per table.
// ----------------------------------------------------------------------------
module lbh_back #(
	parameter int FAMILY_SIZE     = lbh_pkg::FAMILY_SIZE_DEF,
	parameter int NUM_TABLES      = lbh_pkg::NUM_TABLES_DEF,
	parameter int FUNCS_PER_TABLE = lbh_pkg::FUNCS_PER_TABLE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lbh_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output lbh_pkg::res_t res,
	output logic          res_push,
	input  logic          res_full
);

	import lbh_pkg::*;

	localparam int MEMBER_DEPTH = NUM_TABLES * FUNCS_PER_TABLE;
	localparam int FAW = (FAMILY_SIZE > 1) ? $clog2(FAMILY_SIZE) : 1;
	localparam int MAW = (MEMBER_DEPTH > 1) ? $clog2(MEMBER_DEPTH) : 1;
	localparam int PW  = (FUNCS_PER_TABLE > 1) ? $clog2(FUNCS_PER_TABLE) : 1;
	localparam logic [PW-1:0]  POS_LAST = PW'(FUNCS_PER_TABLE - 1);
	localparam logic [5:0]     TBL_LAST = 6'(NUM_TABLES - 1);
	localparam logic [10:0]    FAM_LIM  = 11'(FAMILY_SIZE);

	st_t state_q, state_d;

	// Sequencer controls.
	logic hash_issue, h_clear, tbl_done;

	// Store ports.
	logic              off_we, mem_we, q_we;
	logic [31:0]       off_rdata, q_rdata;
	logic [MIDX_W-1:0] m_rdata;
	logic [12:0]       slot_ext;

	// Projection pipeline.
	logic               proj_go;
	logic signed [64:0] proj_ext, inv_ext, mul_full;
	logic               v_s1, v_s2;
	logic               ok_s1, ok_s2;
	logic [FAW-1:0]     slot_s1, slot_s2;
	logic signed [63:0] mul_s1;
	logic signed [65:0] total_s2;
	logic [33:0]        fl, q_rnd;
	logic               frac_nz;
	logic [31:0]        q_sat;

	// Hash walk.
	logic [PW-1:0]  pos_q;
	logic [MAW-1:0] maddr_q;
	logic [5:0]     tbl_q;
	logic [31:0]    h_q, h_next;
	logic           hv_s1, hlast_s1, hv_s2, hlast_s2, hok_s2;

	assign slot_ext = {3'b000, cmd.slot};
	assign off_we   = cmd_pop && (cmd.kind == CMD_OFFSET) && cmd.in_range;
	assign mem_we   = cmd_pop && (cmd.kind == CMD_MEMBER) && cmd.in_range;
	assign proj_go  = cmd_pop && (cmd.kind == CMD_PROJ);

	lbh_ram #(.WIDTH(32), .DEPTH(FAMILY_SIZE)) u_offset_ram (
		.clk   (clk),
		.we    (off_we),
		.waddr (cmd.slot[FAW-1:0]),
		.wdata (cmd.value),
		.raddr (cmd.slot[FAW-1:0]),
		.rdata (off_rdata)
	);

	lbh_ram #(.WIDTH(MIDX_W), .DEPTH(MEMBER_DEPTH)) u_member_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_ext[MAW-1:0]),
		.wdata (cmd.value[MIDX_W-1:0]),
		.raddr (maddr_q),
		.rdata (m_rdata)
	);

	lbh_ram #(.WIDTH(32), .DEPTH(FAMILY_SIZE)) u_quant_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (slot_s2),
		.wdata (q_sat),
		.raddr (m_rdata[FAW-1:0]),
		.rdata (q_rdata)
	);

	// Stage 1: signed Q16.16 projection times unsigned Q16.16 reciprocal.
	assign proj_ext = $signed({{33{cmd.value[31]}}, cmd.value});
	assign inv_ext  = $signed({33'b0, cmd.inv});
	assign mul_full = proj_ext * inv_ext;

	always_ff @(posedge clk) begin
		mul_s1   <= mul_full[63:0];
		slot_s1  <= cmd.slot[FAW-1:0];
		ok_s1    <= cmd.in_range;
		// Stage 2: add the offset, scaled up to the Q32.32 product grid.
		total_s2 <= $signed({{2{mul_s1[63]}}, mul_s1})
			+ $signed({{18{off_rdata[31]}}, off_rdata, 16'b0});
		slot_s2  <= slot_s1;
		ok_s2    <= ok_s1;
	end

	// Stage 3: floor to the integer part, move negatives with a fraction
	// one step up so the result truncates toward zero, then saturate.
	assign fl      = total_s2[65:32];
	assign frac_nz = |total_s2[31:0];
	assign q_rnd   = fl + {33'b0, (fl[33] && frac_nz)};

	always_comb begin
		if (!q_rnd[33] && (q_rnd[32:31] != 2'b00)) begin
			q_sat = 32'h7fff_ffff;
		end else if (q_rnd[33] && (q_rnd[32:31] != 2'b11)) begin
			q_sat = 32'h8000_0000;
		end else begin
			q_sat = q_rnd[31:0];
		end
	end

	assign q_we = v_s2 && ok_s2;

	// Hash fold: member read, then quantized read, then one combine a cycle.
	assign h_next   = hash_combine(h_q, hok_s2 ? q_rdata : 32'h0);
	assign res_push = hv_s2 && hlast_s2;
	assign tbl_done = (tbl_q == TBL_LAST);

	always_comb begin
		res.table_number = tbl_q;
		res.hash_word    = h_next;
		res.last_table   = tbl_done;
	end

	always_ff @(posedge clk) begin
		hok_s2 <= ({1'b0, m_rdata} < FAM_LIM);
		if (h_clear) begin
			h_q <= '0;
		end else if (hv_s2) begin
			h_q <= h_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			hv_s1    <= 1'b0;
			hlast_s1 <= 1'b0;
			hv_s2    <= 1'b0;
			hlast_s2 <= 1'b0;
			pos_q    <= '0;
			maddr_q  <= '0;
			tbl_q    <= '0;
		end else begin
			state_q  <= state_d;
			v_s1     <= proj_go;
			v_s2     <= v_s1;
			hv_s1    <= hash_issue;
			hlast_s1 <= hash_issue && (pos_q == POS_LAST);
			hv_s2    <= hv_s1;
			hlast_s2 <= hlast_s1;
			if (h_clear) begin
				pos_q <= '0;
			end else if (hash_issue) begin
				pos_q <= pos_q + 1'b1;
			end
			if (res_push) begin
				tbl_q <= tbl_done ? '0 : tbl_q + 1'b1;
				if (tbl_done) begin
					maddr_q <= '0;
				end
			end else if (hash_issue) begin
				maddr_q <= maddr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		hash_issue = 1'b0;
		h_clear    = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				cmd_pop = !cmd_empty;
				if (!cmd_empty && (cmd.kind == CMD_PROJ) && cmd.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_TSTART;
				end
			end
			ST_TSTART: begin
				if (!res_full) begin
					h_clear = 1'b1;
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				hash_issue = 1'b1;
				if (pos_q == POS_LAST) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (res_push) begin
					state_d = tbl_done ? ST_RUN : ST_TSTART;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("hash word pushed into a full result queue");

	a_hash_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HASH) |-> (!v_s1 && !v_s2))
		else $error("hash walk started with projections in flight");

	a_push_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (state_q == ST_WAIT))
		else $error("table result outside the wait state");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		hv_s1 |-> !v_s2)
		else $error("quantized store written during hash read");

endmodule

// ===== hw/rtl/lsh_bucket_hash.sv =====
// ----------------------------------------------------------------------------
// lsh_bucket_hash: quantize and hash-combine back end for LSH search
// Loads offsets and table members, quantizes projections and folds one
// golden-ratio hash word per table at the end of each point.
// ----------------------------------------------------------------------------
// Usage. Input beats enter through push/full; each carries func, slot,
// value, radius_rank and last_element. An offset load (func 0) and a member
// load (func 1) only fill the stores. A projection (func 2) is multiplied by
// the reciprocal radius of its rank, offset and truncated toward zero into
// the quantized store. The projection marked last_element starts the hash
// walk, which delivers NUM_TABLES result beats (table 0 first, last_table on
// the final one) through empty/pop. Func 3 is taken and dropped.
// The radius registers are written through cfg_valid/cfg_ready, always ready.
// The user must write them only while no point is in flight; nothing checks it.
// Throughput: the front decodes one beat per cycle into a four-entry command
// queue until it is full, and the back executes one load or projection per
// cycle while in its run state. After the last projection the quantize
// pipeline drains, then each table's members are walked serially through
// the member and quantized store read ports.
// Input beats keep queueing during the walk until the command queue fills.
// If the receiver stalls, the walk holds before each table until the result
// queue has room. Reset clears the queues, the sequencer and sets every
// reciprocal radius to 1.0; the stores hold garbage until written.
// ----------------------------------------------------------------------------
module lsh_bucket_hash #(
	parameter int FAMILY_SIZE     = lbh_pkg::FAMILY_SIZE_DEF,
	parameter int NUM_TABLES      = lbh_pkg::NUM_TABLES_DEF,
	parameter int FUNCS_PER_TABLE = lbh_pkg::FUNCS_PER_TABLE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Input queue side.
	input  logic               push,
	output logic               full,
	input  logic [1:0]         func,
	input  logic [9:0]         slot,
	input  logic signed [31:0] value,
	input  logic [1:0]         radius_rank,
	input  logic               last_element,
	// Result queue side.
	output logic               empty,
	input  logic               pop,
	output logic [5:0]         table_number,
	output logic [31:0]        hash_word,
	output logic               last_table,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	import lbh_pkg::*;

	localparam int MEMBER_DEPTH = NUM_TABLES * FUNCS_PER_TABLE;

	cmd_t cmd_in, cmd_head;
	logic cmd_push, cmd_pop, cmd_empty;
	res_t res_in, res_head;
	logic res_push, res_full;

	// The front turns an input beat into a command; the queue behind it
	// lets the back stall through a hash walk without blocking input.
	lbh_front #(
		.FAMILY_SIZE  (FAMILY_SIZE),
		.MEMBER_DEPTH (MEMBER_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.slot         (slot),
		.value        (value),
		.radius_rank  (radius_rank),
		.last_element (last_element),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd_in),
		.cmd_push     (cmd_push)
	);

	// The input side reports full straight from the command queue, so a
	// beat is taken whenever the queue has a free entry.
	lbh_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_head),
		.empty  (cmd_empty)
	);

	lbh_back #(
		.FAMILY_SIZE     (FAMILY_SIZE),
		.NUM_TABLES      (NUM_TABLES),
		.FUNCS_PER_TABLE (FUNCS_PER_TABLE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	// Result queue: the head entry drives the result ports while not empty.
	lbh_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_head),
		.empty  (empty)
	);

	assign table_number = res_head.table_number;
	assign hash_word    = res_head.hash_word;
	assign last_table   = res_head.last_table;

endmodule
